// ----- src/jpeg_frame_size_estimator_macros.svh -----
// Assertion macros shared by the checker files of the estimator.
`ifndef JPEG_FRAME_SIZE_ESTIMATOR_MACROS_SVH
`define JPEG_FRAME_SIZE_ESTIMATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define JFSE_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("jfse assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define JFSE_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("jfse assertion failed");

`endif

// ----- src/jfse_pkg.sv -----
package jfse_pkg;

    // Marker codes that follow an FF byte.
    localparam logic [7:0] MK_FF   = 8'hFF;
    localparam logic [7:0] MK_SOI  = 8'hD8;
    localparam logic [7:0] MK_SOS  = 8'hDA;
    localparam logic [7:0] MK_EOI  = 8'hD9;
    localparam logic [7:0] MK_SOF0 = 8'hC0;
    localparam logic [7:0] MK_SOF2 = 8'hC2;
    localparam logic [7:0] MK_RST0 = 8'hD0;
    localparam logic [7:0] MK_RST7 = 8'hD7;
    localparam logic [7:0] MK_TEM  = 8'h01;
    localparam logic [7:0] MK_STUF = 8'h00;

    localparam int EST_W = 34;
    localparam int DIM_W = 16;

    // Offsets of the geometry bytes inside a frame header body.
    localparam logic [3:0] OFF_H_HI = 4'd1;
    localparam logic [3:0] OFF_H_LO = 4'd2;
    localparam logic [3:0] OFF_W_HI = 4'd3;
    localparam logic [3:0] OFF_W_LO = 4'd4;
    localparam logic [3:0] OFF_MAX  = 4'd15;

    // Smallest body length counted for a frame header.
    localparam logic [15:0] SOF_MIN_BODY = 16'd5;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // One job for the back end: the estimate is w * h * 3.
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [8:0] {
        PH_SOI0 = 9'b000000001,
        PH_SOI1 = 9'b000000010,
        PH_SCAN = 9'b000000100,
        PH_MARK = 9'b000001000,
        PH_LENH = 9'b000010000,
        PH_LENL = 9'b000100000,
        PH_SKIP = 9'b001000000,
        PH_SOF  = 9'b010000000,
        PH_DONE = 9'b100000000
    } phase_t;

    typedef enum logic [3:0] {
        BK_IDLE = 4'b0001,
        BK_MUL  = 4'b0010,
        BK_TRIP = 4'b0100,
        BK_OUT  = 4'b1000
    } back_state_t;

endpackage

// ----- src/jpeg_frame_size_estimator.sv -----
// JPEG frame size estimator: bytes of a JPEG file enter one word per cycle on
// data_byte, with last_byte marking the final byte of each file. The front end
// checks the SOI signature and walks the marker segments, skipping fill bytes,
// stuffed zeros, standalone markers and length-delimited segments; it captures
// height and width from an SOF0, SOF1 or SOF2 header. Every file yields exactly
// one estimate word, width * height * 3, or zero when the signature is bad, the
// walk hits SOS or EOI, a segment length is below two, the geometry is zero,
// or the file ends before a decision. Bytes that follow the decision are
// consumed silently until last_byte, after which the block re-arms. Bytes are
// taken at one per cycle while the two-entry job queue has room. A job leaves
// the queue into a back end that works through it in steps (load, 16 by 16
// multiply, times three, present): the job is held in the queue, then in the
// job, product and estimate registers before the estimate is offered. The
// front end keeps parsing meanwhile and stalls whenever the queue holds two
// jobs, which happens when files are decided faster than the back end
// finishes them or when results wait behind a stalled output.
module jpeg_frame_size_estimator
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         data_byte,
    input  logic                               last_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [jfse_pkg::EST_W-1:0]         estimate
);

    jfse_pkg::queue_status_t q_status;
    jfse_pkg::job_t          push_job;
    jfse_pkg::job_t          head_job;
    logic                    push;
    logic                    pop;

    // Marker parser: one byte per cycle while the job queue has room, pushes one job per file.
    jfse_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_status  (q_status),
        .push      (push),
        .push_job  (push_job)
    );

    // Short queue that lets the parser run ahead of the multiplier.
    jfse_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // Multiplier and output register.
    jfse_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .estimate  (estimate)
    );

endmodule

// ----- src/jfse_front.sv -----
module jfse_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    input  jfse_pkg::queue_status_t q_status,
    output logic                   push,
    output jfse_pkg::job_t         push_job
);

    jfse_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  marker_reg, marker_next;
    logic [7:0]  lenh_reg, lenh_next;
    logic [15:0] rem_reg, rem_next;
    logic [3:0]  off_reg, off_next;
    logic [15:0] height_reg, height_next;
    logic [15:0] width_reg, width_next;

    logic        accept;
    logic        emit;
    logic [15:0] seg_len;
    logic [15:0] body_len;

    // A result may be pushed by any byte, so a byte is only taken when a slot is free.
    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;
    assign seg_len  = {lenh_reg, data_byte};
    assign body_len = seg_len - 16'd2;

    always_comb
    begin
        phase_next  = phase_reg;
        marker_next = marker_reg;
        lenh_next   = lenh_reg;
        rem_next    = rem_reg;
        off_next    = off_reg;
        height_next = height_reg;
        width_next  = width_reg;
        emit        = 1'b0;
        push        = 1'b0;
        push_job    = '0;
        if (accept)
        begin
            unique case (phase_reg)
                jfse_pkg::PH_SOI0:
                begin
                    if (data_byte == jfse_pkg::MK_FF)
                        phase_next = jfse_pkg::PH_SOI1;
                    else
                        emit = 1'b1;
                end
                jfse_pkg::PH_SOI1:
                begin
                    if (data_byte == jfse_pkg::MK_SOI)
                        phase_next = jfse_pkg::PH_SCAN;
                    else
                        emit = 1'b1;
                end
                jfse_pkg::PH_SCAN:
                begin
                    if (data_byte == jfse_pkg::MK_FF)
                        phase_next = jfse_pkg::PH_MARK;
                end
                jfse_pkg::PH_MARK:
                begin
                    priority if (data_byte == jfse_pkg::MK_FF)
                    begin
                        phase_next = jfse_pkg::PH_MARK;
                    end
                    else if (data_byte == jfse_pkg::MK_EOI || data_byte == jfse_pkg::MK_SOS)
                    begin
                        emit = 1'b1;
                    end
                    else if (data_byte == jfse_pkg::MK_STUF || data_byte == jfse_pkg::MK_SOI ||
                             data_byte == jfse_pkg::MK_TEM ||
                             (data_byte >= jfse_pkg::MK_RST0 && data_byte <= jfse_pkg::MK_RST7))
                    begin
                        phase_next = jfse_pkg::PH_SCAN;
                    end
                    else
                    begin
                        marker_next = data_byte;
                        phase_next  = jfse_pkg::PH_LENH;
                    end
                end
                jfse_pkg::PH_LENH:
                begin
                    lenh_next  = data_byte;
                    phase_next = jfse_pkg::PH_LENL;
                end
                jfse_pkg::PH_LENL:
                begin
                    priority if (seg_len < 16'd2)
                    begin
                        emit = 1'b1;
                    end
                    else if (marker_reg >= jfse_pkg::MK_SOF0 && marker_reg <= jfse_pkg::MK_SOF2)
                    begin
                        // A short frame header still reads the geometry bytes past its end.
                        rem_next    = (body_len > jfse_pkg::SOF_MIN_BODY) ? body_len
                                                                         : jfse_pkg::SOF_MIN_BODY;
                        off_next    = '0;
                        height_next = '0;
                        width_next  = '0;
                        phase_next  = jfse_pkg::PH_SOF;
                    end
                    else if (seg_len == 16'd2)
                    begin
                        phase_next = jfse_pkg::PH_SCAN;
                    end
                    else
                    begin
                        rem_next   = body_len;
                        phase_next = jfse_pkg::PH_SKIP;
                    end
                end
                jfse_pkg::PH_SKIP:
                begin
                    rem_next = rem_reg - 16'd1;
                    if (rem_next == 16'd0)
                        phase_next = jfse_pkg::PH_SCAN;
                end
                jfse_pkg::PH_SOF:
                begin
                    if (off_reg == jfse_pkg::OFF_H_HI)
                        height_next = {data_byte, height_reg[7:0]};
                    if (off_reg == jfse_pkg::OFF_H_LO)
                        height_next = {height_reg[15:8], data_byte};
                    if (off_reg == jfse_pkg::OFF_W_HI)
                        width_next = {data_byte, width_reg[7:0]};
                    if (off_reg == jfse_pkg::OFF_W_LO)
                        width_next = {width_reg[15:8], data_byte};
                    if (off_reg < jfse_pkg::OFF_MAX)
                        off_next = off_reg + 4'd1;
                    rem_next = rem_reg - 16'd1;
                    if (rem_next == 16'd0)
                    begin
                        emit            = 1'b1;
                        push_job.width  = width_next;
                        push_job.height = height_next;
                    end
                end
                jfse_pkg::PH_DONE:
                begin
                    phase_next = jfse_pkg::PH_DONE;
                end
                default:
                begin
                    phase_next = jfse_pkg::PH_SOI0;
                end
            endcase

            if (emit)
            begin
                push       = 1'b1;
                phase_next = jfse_pkg::PH_DONE;
            end
            else if (last_byte && phase_reg != jfse_pkg::PH_DONE)
            begin
                // The file ended before anything was decided.
                push     = 1'b1;
                push_job = '0;
            end

            if (last_byte)
                phase_next = jfse_pkg::PH_SOI0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= jfse_pkg::PH_SOI0;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        marker_reg <= marker_next;
        lenh_reg   <= lenh_next;
        rem_reg    <= rem_next;
        off_reg    <= off_next;
        height_reg <= height_next;
        width_reg  <= width_next;
    end

endmodule

// ----- src/jfse_queue.sv -----
module jfse_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  jfse_pkg::job_t          push_job,
    input  logic                    pop,
    output jfse_pkg::job_t          head_job,
    output jfse_pkg::queue_status_t status
);

    jfse_pkg::job_t              slot_reg [jfse_pkg::QDEPTH];
    logic [jfse_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [jfse_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [jfse_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                        do_push;
    logic                        do_pop;

    assign status.full  = (count_reg == jfse_pkg::QCNT_W'(jfse_pkg::QDEPTH));
    assign status.empty = (count_reg == '0);
    assign head_job     = slot_reg[rd_ptr_reg];
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == jfse_pkg::QPTR_W'(jfse_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == jfse_pkg::QPTR_W'(jfse_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ----- src/jfse_back.sv -----
module jfse_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  jfse_pkg::job_t                head_job,
    input  jfse_pkg::queue_status_t       q_status,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [jfse_pkg::EST_W-1:0]    estimate
);

    localparam int PROD_W = 2 * jfse_pkg::DIM_W;

    jfse_pkg::back_state_t         state_reg, state_next;
    jfse_pkg::job_t                job_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic [jfse_pkg::EST_W-1:0]    est_reg;

    assign pop       = (state_reg == jfse_pkg::BK_IDLE) && !q_status.empty;
    assign out_valid = (state_reg == jfse_pkg::BK_OUT);
    assign estimate  = est_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            jfse_pkg::BK_IDLE: if (!q_status.empty) state_next = jfse_pkg::BK_MUL;
            jfse_pkg::BK_MUL:  state_next = jfse_pkg::BK_TRIP;
            jfse_pkg::BK_TRIP: state_next = jfse_pkg::BK_OUT;
            jfse_pkg::BK_OUT:  if (!out_stall) state_next = jfse_pkg::BK_IDLE;
            default:           state_next = jfse_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= jfse_pkg::BK_IDLE;
        else
            state_reg <= state_next;
    end

    // A zero width or height yields a zero product, which covers every zero result.
    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= head_job;
        if (state_reg == jfse_pkg::BK_MUL)
            prod_reg <= job_reg.width * job_reg.height;
        if (state_reg == jfse_pkg::BK_TRIP)
            est_reg <= {2'b00, prod_reg} + {1'b0, prod_reg, 1'b0};
    end

endmodule

// ----- src/jfse_checker.sv -----
`include "jpeg_frame_size_estimator_macros.svh"

module jfse_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [7:0]                   data_byte,
    input  logic                         last_byte,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [jfse_pkg::EST_W-1:0]   estimate
);

    logic in_seen;

    // Marks that the input side was live, keeping every port in use.
    assign in_seen = in_valid || in_stall || last_byte || (data_byte != 8'h00);

    // A stalled result stays offered.
    `JFSE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // A stalled result keeps its value.
    `JFSE_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(estimate))

    // No estimate exceeds the largest frame times three.
    `JFSE_ASSERT_NOW(a_est_range, clk, rst_n, out_valid, estimate <= 34'd12884508675)

    // The back end returns to idle after each result, so results never come back to back.
    `JFSE_ASSERT_NEXT(a_out_gap, clk, rst_n, out_valid && !out_stall, !out_valid || in_seen)

endmodule

bind jpeg_frame_size_estimator jfse_checker u_jfse_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    // Segment markers that the block treats as plain length-delimited segments.
    localparam logic [7:0] MK_APP0 = 8'hE0;
    localparam logic [7:0] MK_APP5 = 8'hE5;
    localparam logic [7:0] MK_DQT  = 8'hDB;
    localparam logic [7:0] MK_COM  = 8'hFE;

    localparam int RANDOM_ITEMS   = 1050;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    // Tracks the marker walk of the file being streamed and keeps the estimates
    // that the block still owes, oldest first.
    class frame_estimate_tracker;
        jfse_pkg::phase_t           walk;
        logic [7:0]                 seg_marker;
        logic [7:0]                 seg_len_hi;
        logic [15:0]                seg_left;
        logic [3:0]                 hdr_pos;
        logic [15:0]                frame_h;
        logic [15:0]                frame_w;
        bit                         decided;
        logic [jfse_pkg::EST_W-1:0] estimates_due[$];
        int                         errors;

        function new();
            errors = 0;
            rearm();
        endfunction

        function void rearm();
            walk       = jfse_pkg::PH_SOI0;
            seg_marker = '0;
            seg_len_hi = '0;
            seg_left   = '0;
            hdr_pos    = '0;
            frame_h    = '0;
            frame_w    = '0;
            decided    = 1'b0;
        endfunction

        function int outstanding();
            return estimates_due.size();
        endfunction

        // Advances the walk by one accepted byte and queues the estimate it causes.
        function void take_byte(logic [7:0] b, logic is_last);
            logic [15:0]                seg_len;
            bit                         give;
            logic [jfse_pkg::EST_W-1:0] value;
            give  = 1'b0;
            value = '0;
            case (walk)
                jfse_pkg::PH_SOI0:
                begin
                    if (b == jfse_pkg::MK_FF) walk = jfse_pkg::PH_SOI1;
                    else give = 1'b1;
                end
                jfse_pkg::PH_SOI1:
                begin
                    if (b == jfse_pkg::MK_SOI) walk = jfse_pkg::PH_SCAN;
                    else give = 1'b1;
                end
                jfse_pkg::PH_SCAN:
                begin
                    if (b == jfse_pkg::MK_FF) walk = jfse_pkg::PH_MARK;
                end
                jfse_pkg::PH_MARK:
                begin
                    if (b == jfse_pkg::MK_FF)
                    begin
                        // A fill byte; the marker code is still to come.
                    end
                    else if (b == jfse_pkg::MK_EOI || b == jfse_pkg::MK_SOS)
                        give = 1'b1;
                    else if (b == jfse_pkg::MK_STUF || b == jfse_pkg::MK_SOI ||
                             b == jfse_pkg::MK_TEM ||
                             (b >= jfse_pkg::MK_RST0 && b <= jfse_pkg::MK_RST7))
                        walk = jfse_pkg::PH_SCAN;
                    else
                    begin
                        seg_marker = b;
                        walk = jfse_pkg::PH_LENH;
                    end
                end
                jfse_pkg::PH_LENH:
                begin
                    seg_len_hi = b;
                    walk = jfse_pkg::PH_LENL;
                end
                jfse_pkg::PH_LENL:
                begin
                    seg_len = {seg_len_hi, b};
                    if (seg_len < 16'd2)
                        give = 1'b1;
                    else if (seg_marker >= jfse_pkg::MK_SOF0 &&
                             seg_marker <= jfse_pkg::MK_SOF2)
                    begin
                        seg_left = (seg_len - 16'd2 > jfse_pkg::SOF_MIN_BODY) ?
                                   seg_len - 16'd2 : jfse_pkg::SOF_MIN_BODY;
                        hdr_pos = '0;
                        frame_h = '0;
                        frame_w = '0;
                        walk = jfse_pkg::PH_SOF;
                    end
                    else if (seg_len == 16'd2)
                        walk = jfse_pkg::PH_SCAN;
                    else
                    begin
                        seg_left = seg_len - 16'd2;
                        walk = jfse_pkg::PH_SKIP;
                    end
                end
                jfse_pkg::PH_SKIP:
                begin
                    seg_left = seg_left - 16'd1;
                    if (seg_left == '0) walk = jfse_pkg::PH_SCAN;
                end
                jfse_pkg::PH_SOF:
                begin
                    case (hdr_pos)
                        jfse_pkg::OFF_H_HI: frame_h[15:8] = b;
                        jfse_pkg::OFF_H_LO: frame_h[7:0]  = b;
                        jfse_pkg::OFF_W_HI: frame_w[15:8] = b;
                        jfse_pkg::OFF_W_LO: frame_w[7:0]  = b;
                        default: ;
                    endcase
                    if (hdr_pos < jfse_pkg::OFF_MAX) hdr_pos = hdr_pos + 4'd1;
                    seg_left = seg_left - 16'd1;
                    if (seg_left == '0)
                    begin
                        give = 1'b1;
                        if (frame_w != '0 && frame_h != '0)
                            value = {18'd0, frame_w} * {18'd0, frame_h} * 34'd3;
                    end
                end
                default: ;
            endcase

            if (give)
            begin
                walk = jfse_pkg::PH_DONE;
                decided = 1'b1;
            end
            else if (is_last && !decided)
            begin
                give = 1'b1;
                value = '0;
            end
            if (is_last) rearm();
            if (give) estimates_due.push_back(value);
        endfunction

        function void check_estimate(logic [jfse_pkg::EST_W-1:0] actual);
            logic [jfse_pkg::EST_W-1:0] wanted;
            if (estimates_due.size() == 0)
            begin
                errors++;
                $display("%0t: estimate %0d arrived with none expected", $time, actual);
            end
            else
            begin
                wanted = estimates_due.pop_front();
                if (actual !== wanted)
                begin
                    errors++;
                    $display("%0t: estimate wrong, expected %0d, actual %0d",
                             $time, wanted, actual);
                end
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [7:0]                 data_byte;
    logic                       last_byte;
    logic                       out_valid;
    logic                       out_stall;
    logic [jfse_pkg::EST_W-1:0] estimate;

    frame_estimate_tracker tracker;

    // Bytes of the file that is about to be streamed.
    logic [7:0] jpeg_bytes[$];
    int         items_sent;
    // While calm is set neither side idles; hold_req asks the receiver for one
    // long stall so that the job queue fills and the input backs up.
    bit         calm;
    bit         hold_req;

    jpeg_frame_size_estimator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .estimate  (estimate)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Both handshakes are observed in one place so that a word accepted on the
    // input is always noted before a result of the same edge is checked.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall) tracker.take_byte(data_byte, last_byte);
        if (rst_n && out_valid && !out_stall) tracker.check_estimate(estimate);
    end

    // Idle stretches are mostly short, now and then long, and absent when calm.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Frame dimensions lean toward the extremes: zero, one and full scale.
    function automatic logic [15:0] pick_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'h0001;
        if (r == 2) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Offers one word and returns once the block has taken it. Idle cycles go in
    // front of the word; the payload is scrambled while valid is low.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid  = 1'b0;
            data_byte = 8'($urandom);
            last_byte = 1'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        data_byte = b;
        last_byte = is_last;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_file();
        foreach (jpeg_bytes[i]) send_byte(jpeg_bytes[i], i == jpeg_bytes.size() - 1);
        jpeg_bytes.delete();
    endtask

    task automatic wait_for_estimates();
        while (tracker.outstanding() != 0) @(posedge clk);
    endtask

    // Builds one file. Most files carry a valid signature, a few standalone
    // markers and skipped segments, and then one way of ending the walk; the
    // rest is raw noise, truncated files and trailing junk after the decision.
    task automatic build_random_file();
        int          pick;
        int          n;
        int          seg_len;
        logic [7:0]  code;
        logic [15:0] h;
        logic [15:0] w;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            n = $urandom_range(1, 6);
            repeat (n) jpeg_bytes.push_back(8'($urandom));
            return;
        end
        jpeg_bytes.push_back(jfse_pkg::MK_FF);
        jpeg_bytes.push_back(jfse_pkg::MK_SOI);

        n = $urandom_range(0, 4);
        repeat (n)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    // Entropy-like bytes between markers are skipped.
                    repeat ($urandom_range(1, 3))
                        jpeg_bytes.push_back(8'($urandom_range(0, 254)));
                end
                1, 2:
                begin
                    // Optional fill bytes, then a marker that stands alone.
                    jpeg_bytes.push_back(jfse_pkg::MK_FF);
                    if (pick[0]) jpeg_bytes.push_back(jfse_pkg::MK_FF);
                    case ($urandom_range(0, 3))
                        0: code = jfse_pkg::MK_STUF;
                        1: code = jfse_pkg::MK_SOI;
                        2: code = jfse_pkg::MK_TEM;
                        default: code = 8'(jfse_pkg::MK_RST0 + $urandom_range(0, 7));
                    endcase
                    jpeg_bytes.push_back(code);
                end
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                        code = 8'($urandom_range(2, 8'hBF));
                    else
                        code = 8'($urandom_range(MK_DQT, MK_COM));
                    if ($urandom_range(0, 99) < 2)
                        seg_len = $urandom_range(100, 400);
                    else
                        seg_len = $urandom_range(2, 12);
                    jpeg_bytes.push_back(jfse_pkg::MK_FF);
                    jpeg_bytes.push_back(code);
                    jpeg_bytes.push_back(8'(seg_len >> 8));
                    jpeg_bytes.push_back(8'(seg_len));
                    repeat (seg_len - 2) jpeg_bytes.push_back(8'($urandom));
                end
            endcase
        end

        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            // Frame header; short lengths still read geometry past the segment.
            pick = $urandom_range(0, 9);
            if (pick < 7)
                seg_len = 8 + 3 * $urandom_range(1, 4);
            else if (pick < 9)
                seg_len = $urandom_range(2, 6);
            else
                seg_len = $urandom_range(0, 24);
            h = pick_dim();
            w = pick_dim();
            jpeg_bytes.push_back(jfse_pkg::MK_FF);
            jpeg_bytes.push_back(8'(jfse_pkg::MK_SOF0 + $urandom_range(0, 2)));
            jpeg_bytes.push_back(8'(seg_len >> 8));
            jpeg_bytes.push_back(8'(seg_len));
            if (seg_len >= 2)
            begin
                n = (seg_len - 2 > 5) ? seg_len - 2 : 5;
                jpeg_bytes.push_back(8'($urandom));
                jpeg_bytes.push_back(h[15:8]);
                jpeg_bytes.push_back(h[7:0]);
                jpeg_bytes.push_back(w[15:8]);
                jpeg_bytes.push_back(w[7:0]);
                repeat (n - 5) jpeg_bytes.push_back(8'($urandom));
            end
        end
        else if (pick < 65)
        begin
            jpeg_bytes.push_back(jfse_pkg::MK_FF);
            jpeg_bytes.push_back(jfse_pkg::MK_SOS);
        end
        else if (pick < 73)
        begin
            jpeg_bytes.push_back(jfse_pkg::MK_FF);
            jpeg_bytes.push_back(jfse_pkg::MK_EOI);
        end
        else if (pick < 80)
        begin
            // A length below two ends the walk at its low byte.
            jpeg_bytes.push_back(jfse_pkg::MK_FF);
            jpeg_bytes.push_back(MK_APP0);
            jpeg_bytes.push_back(8'h00);
            jpeg_bytes.push_back(8'($urandom_range(0, 1)));
        end
        else if (pick < 90)
        begin
            // The file ends inside a segment with an arbitrary 16-bit length.
            jpeg_bytes.push_back(jfse_pkg::MK_FF);
            jpeg_bytes.push_back(MK_APP5);
            jpeg_bytes.push_back(8'($urandom));
            jpeg_bytes.push_back(8'($urandom));
            repeat ($urandom_range(0, 4)) jpeg_bytes.push_back(8'($urandom));
        end

        // Bytes after the decision must be swallowed until the last one.
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) jpeg_bytes.push_back(8'($urandom));
    endtask

    // The receiver stalls at random, and once, on request, for a long stretch.
    initial
    begin
        int stall_len;
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req  = 1'b0;
                out_stall = 1'b0;
            end
            else
            begin
                stall_len = pick_gap();
                out_stall = (stall_len != 0);
                if (stall_len > 1) repeat (stall_len - 1) @(negedge clk);
            end
        end
    end

    // Ends the run when no word moves on either side for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int file_no;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_byte  = '0;
        last_byte  = 1'b0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        items_sent = 0;
        tracker    = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed files: a bad first byte, a bad second byte, a walk over
        // scan bytes, fill, stuffing, restart, TEM and SOI that ends at EOI,
        // a short frame header with full-scale geometry, and a file that ends
        // right after its signature.
        jpeg_bytes = {8'h00};
        send_file();
        jpeg_bytes = {jfse_pkg::MK_FF, jfse_pkg::MK_RST7};
        send_file();
        jpeg_bytes = {jfse_pkg::MK_FF, jfse_pkg::MK_SOI, 8'h5A, jfse_pkg::MK_FF,
                      jfse_pkg::MK_FF, jfse_pkg::MK_STUF, jfse_pkg::MK_FF,
                      jfse_pkg::MK_RST0, jfse_pkg::MK_FF, jfse_pkg::MK_TEM,
                      jfse_pkg::MK_FF, jfse_pkg::MK_SOI, jfse_pkg::MK_FF,
                      jfse_pkg::MK_EOI};
        send_file();
        jpeg_bytes = {jfse_pkg::MK_FF, jfse_pkg::MK_SOI, jfse_pkg::MK_FF,
                      jfse_pkg::MK_SOF2, 8'h00, 8'h02,
                      8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_file();
        jpeg_bytes = {jfse_pkg::MK_FF, jfse_pkg::MK_SOI};
        send_file();

        file_no = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            // Every few dozen files, a stretch where neither side idles.
            calm = (file_no % 25) >= 20;
            if (file_no == 15)
            begin
                // One-byte files each owe a result, so a long receiver stall
                // fills the block and the input has to back up.
                calm     = 1'b1;
                hold_req = 1'b1;
                repeat (12)
                begin
                    jpeg_bytes.push_back(8'($urandom_range(0, 254)));
                    send_file();
                end
                calm = 1'b0;
            end
            if (file_no % 20 == 19) wait_for_estimates();
            build_random_file();
            send_file();
            file_no++;
        end

        @(negedge clk);
        in_valid = 1'b0;
        wait_for_estimates();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
